// File: rtl/wgs_pkg.sv
`default_nettype none
package wgs_pkg;

  localparam int unsigned CoeffW  = 18;
  localparam int unsigned HeightW = 16;
  localparam int unsigned PeriodW = 24;
  localparam int unsigned AccumW  = 25;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpPerturb = 2'd1;
  localparam logic [1:0] OpRead    = 2'd2;

  localparam logic [CfgIdxW-1:0] RegCoeffPrev = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCoeffCur  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCoeffNbr  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPeriod    = 2'd3;

  // Which bank a memory access goes to
  typedef enum logic [1:0] {
    SelNone,
    SelCur,
    SelPrev
  } bank_sel_e;

  // Controller states
  typedef enum logic [4:0] {
    StIdle,
    StClear,
    StDecode,
    StPtRd,
    StPtWr,
    StRdRd,
    StRdWait,
    StSwC,
    StSwN,
    StSwS,
    StSwW,
    StSwE,
    StSwP,
    StSwWait,
    StSwMul,
    StSwSum,
    StSwWr,
    StOut
  } state_e;

  // Datapath commands
  typedef struct packed {
    bank_sel_e  rd_sel;     // read port target
    logic [2:0] rd_tap;     // 0 centre,1 north,2 south,3 west,4 east
    logic       clr_wr;     // clear both banks at clear address
    logic       clr_inc;
    logic       pt_wr;      // write perturbed value at current tap
    logic       sw_cap;     // capture read data into neighbor sum / center
    logic       sw_capp;    // capture previous-bank value
    logic       sw_mul;
    logic       sw_sum;
    logic       sw_wr;
    logic       cell_first; // start sweep at first interior cell
    logic       cell_inc;
    logic       swap;
    logic       cap_read;
  } dp_cmd_t;

  // Datapath status
  typedef struct packed {
    logic clr_done;
    logic cell_last;
  } dp_sts_t;

  function automatic logic signed [HeightW-1:0] sat16(input logic signed [HeightW+2:0] v);
    logic signed [HeightW-1:0] r;
    if (v > 19'sd32767) r = 16'sh7fff;
    else if (v < -19'sd32768) r = 16'sh8000;
    else r = v[HeightW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/wgs_datapath.sv
`default_nettype none
module wgs_datapath #(
  parameter int unsigned GridRows = 64,
  parameter int unsigned GridCols = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wgs_pkg::dp_cmd_t                  cmd_i,
  output wgs_pkg::dp_sts_t                  sts_o,
  input  wire logic [7:0]                   row_i,
  input  wire logic [7:0]                   col_i,
  input  wire logic signed [15:0]           mag_i,
  input  wire logic signed [17:0]           k1_i,
  input  wire logic signed [17:0]           k2_i,
  input  wire logic signed [17:0]           k3_i,
  output logic signed [15:0]                read_o
);
  import wgs_pkg::*;

  localparam int unsigned Cells = GridRows * GridCols;
  localparam int unsigned RowW  = $clog2(GridRows);
  localparam int unsigned ColW  = $clog2(GridCols);
  localparam int unsigned AddrW = RowW + ColW;

  // Row-major storage with a power-of-two row stride
  logic [HeightW-1:0] mem_a [2**AddrW];
  logic [HeightW-1:0] mem_b [2**AddrW];

  logic             bank_q;
  logic [AddrW:0]   clr_q;
  logic [RowW-1:0]  r_q;
  logic [ColW-1:0]  c_q;
  logic [2:0]       tap_q;
  logic [HeightW-1:0] rdat_a_q, rdat_b_q;
  logic             rsel_q;
  logic signed [HeightW-1:0] cen_q, prv_q, rd_q;
  logic signed [HeightW+1:0] nsum_q;
  logic signed [35:0] p1_q, p2_q;
  logic signed [37:0] p3_q;
  logic signed [15:0] res_q;

  logic [RowW-1:0]  ar;
  logic [ColW-1:0]  ac;
  logic [AddrW-1:0] addr;
  logic             use_b;
  logic signed [HeightW-1:0] rdat;
  logic signed [HeightW-1:0] half;
  logic signed [HeightW-1:0] pt_val;
  logic [RowW-1:0]  cell_r;
  logic [ColW-1:0]  cell_c;
  logic signed [39:0] acc;
  logic signed [23:0] accs;

  assign cell_r = cmd_i.cap_read ? row_i[RowW-1:0] : r_q;
  assign cell_c = cmd_i.cap_read ? col_i[ColW-1:0] : c_q;

  // Tap address around the working cell
  always_comb begin
    ar = (cmd_i.rd_sel == SelNone && !cmd_i.pt_wr && !cmd_i.sw_wr) ? cell_r : r_q;
    ac = c_q;
    if (cmd_i.rd_sel != SelNone) begin
      ar = row_i[RowW-1:0];
      ac = col_i[ColW-1:0];
      if (cmd_i.sw_cap || cmd_i.sw_capp || cmd_i.sw_wr) begin
        ar = r_q;
        ac = c_q;
      end
    end
    if (cmd_i.rd_sel != SelNone || cmd_i.pt_wr) begin
      if (cmd_i.pt_wr) begin
        ar = row_i[RowW-1:0];
        ac = col_i[ColW-1:0];
      end
    end
    case (cmd_i.pt_wr ? tap_q : cmd_i.rd_tap)
      3'd1: ar = ar - 1'b1;
      3'd2: ar = ar + 1'b1;
      3'd3: ac = ac - 1'b1;
      3'd4: ac = ac + 1'b1;
      default: ;
    endcase
    addr = {ar, ac};
    if (cmd_i.clr_wr) addr = clr_q[AddrW-1:0];
  end

  assign use_b = (cmd_i.rd_sel == SelCur) ? bank_q : !bank_q;
  assign rdat  = rsel_q ? rdat_b_q : rdat_a_q;
  assign half  = mag_i >>> 1;
  assign pt_val = sat16(19'(rdat) + ((tap_q == 3'd0) ? 19'(mag_i) : 19'(half)));

  // Sweep accumulation, Q24.16 rounded to Q24.0
  assign acc  = 40'(p1_q) + 40'(p2_q) + 40'(p3_q) + 40'sd32768;
  assign accs = acc[39:16];

  // Memory ports
  always_ff @(posedge clk_i) begin
    rdat_a_q <= mem_a[addr];
    rdat_b_q <= mem_b[addr];
    if (cmd_i.clr_wr) begin
      mem_a[addr] <= '0;
      mem_b[addr] <= '0;
    end else if (cmd_i.pt_wr) begin
      if (bank_q) mem_b[addr] <= pt_val;
      else mem_a[addr] <= pt_val;
    end else if (cmd_i.sw_wr) begin
      if (bank_q) mem_a[addr] <= res_q;
      else mem_b[addr] <= res_q;
    end
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      clr_q  <= '0;
      r_q    <= '0;
      c_q    <= '0;
      tap_q  <= '0;
      rsel_q <= 1'b0;
    end else begin
      if (cmd_i.rd_sel != SelNone) begin
        rsel_q <= use_b;
        tap_q  <= cmd_i.rd_tap;
      end
      if (cmd_i.clr_inc) clr_q <= clr_q + 1'b1;
      if (cmd_i.swap) bank_q <= !bank_q;
      if (cmd_i.cell_first) begin
        r_q <= RowW'(1);
        c_q <= ColW'(1);
      end else if (cmd_i.cell_inc) begin
        if (c_q == ColW'(GridCols - 2)) begin
          c_q <= ColW'(1);
          r_q <= r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end
  end

  // Arithmetic pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.sw_cap) begin
      if (tap_q == 3'd0) begin
        cen_q  <= rdat;
        nsum_q <= '0;
      end else begin
        nsum_q <= nsum_q + 18'(rdat);
      end
    end
    if (cmd_i.sw_capp) prv_q <= rdat;
    if (cmd_i.sw_mul) begin
      p1_q <= k1_i * prv_q;
      p2_q <= k2_i * cen_q;
      p3_q <= k3_i * nsum_q;
    end
    if (cmd_i.sw_sum) begin
      if (accs > 24'sd32767) res_q <= 16'sh7fff;
      else if (accs < -24'sd32768) res_q <= 16'sh8000;
      else res_q <= accs[15:0];
    end
    if (cmd_i.cap_read) rd_q <= rdat;
  end

  assign read_o = rd_q;
  assign sts_o.clr_done  = (clr_q == (AddrW+1)'(2**AddrW - 1));
  assign sts_o.cell_last = (r_q == RowW'(GridRows - 2)) && (c_q == ColW'(GridCols - 2));

  logic unused;
  assign unused = ^{Cells, cell_r, cell_c};

endmodule
`default_nettype wire

// File: rtl/wgs_ctrl.sv
`default_nettype none
module wgs_ctrl #(
  parameter int unsigned GridRows = 64,
  parameter int unsigned GridCols = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [7:0]           row_i,
  input  wire logic [7:0]           col_i,
  input  wire logic [15:0]          elapsed_i,
  input  wire logic [23:0]          period_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      stepped_o,
  output logic                      rejected_o,
  output logic                      is_read_o,
  output wgs_pkg::dp_cmd_t          cmd_o,
  input  wgs_pkg::dp_sts_t          sts_i
);
  import wgs_pkg::*;

  state_e state_q, state_d;
  logic [1:0] op_q;
  logic [7:0] row_q, col_q;
  logic [AccumW-1:0] acc_q, acc_d;
  logic [2:0] tap_q, tap_d;
  logic stepped_q, stepped_d, rej_q, rej_d, rd_q, rd_d;
  logic [AccumW-1:0] sum;
  logic pt_ok, rd_ok, last_q, last_d;

  assign sum   = acc_q + AccumW'(elapsed_i);
  assign pt_ok = row_i >= 8'd2 && 9'(row_i) <= 9'(GridRows - 3)
              && col_i >= 8'd2 && 9'(col_i) <= 9'(GridCols - 3);
  assign rd_ok = 9'(row_i) < 9'(GridRows) && 9'(col_i) < 9'(GridCols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      acc_q <= '0;
      tap_q <= '0;
      stepped_q <= 1'b0;
      rej_q <= 1'b0;
      rd_q <= 1'b0;
      last_q <= 1'b0;
      op_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else begin
      state_q <= state_d;
      acc_q <= acc_d;
      tap_q <= tap_d;
      stepped_q <= stepped_d;
      rej_q <= rej_d;
      rd_q <= rd_d;
      last_q <= last_d;
      if (in_valid_i && in_ready_o) begin
        op_q <= opcode_i;
        row_q <= row_i;
        col_q <= col_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    acc_d = acc_q;
    tap_d = tap_q;
    stepped_d = stepped_q;
    rej_d = rej_q;
    rd_d = rd_q;
    last_d = last_q;
    cmd_o = '0;
    cmd_o.rd_sel = SelNone;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        cmd_o.clr_inc = 1'b1;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          stepped_d = 1'b0;
          rej_d = 1'b0;
          rd_d = 1'b0;
          tap_d = '0;
          case (opcode_i)
            OpTick: begin
              if (sum >= AccumW'(period_i)) begin
                acc_d = '0;
                stepped_d = 1'b1;
                cmd_o.cell_first = 1'b1;
                state_d = StSwC;
              end else begin
                acc_d = sum;
                state_d = StOut;
              end
            end
            OpPerturb: begin
              if (pt_ok) state_d = StPtRd;
              else begin
                rej_d = 1'b1;
                state_d = StOut;
              end
            end
            OpRead: begin
              if (rd_ok) begin
                rd_d = 1'b1;
                state_d = StRdRd;
              end else begin
                rej_d = 1'b1;
                state_d = StOut;
              end
            end
            default: state_d = StOut;
          endcase
        end
      end
      // Perturb: read-modify-write over five taps, write while read data is held
      StPtRd: begin
        cmd_o.rd_sel = SelCur;
        cmd_o.rd_tap = tap_q;
        state_d = StPtWr;
      end
      StPtWr: begin
        cmd_o.pt_wr = 1'b1;
        if (tap_q == 3'd4) state_d = StOut;
        else begin
          tap_d = tap_q + 1'b1;
          state_d = StPtRd;
        end
      end
      StRdRd: begin
        cmd_o.rd_sel = SelCur;
        cmd_o.rd_tap = 3'd0;
        state_d = StRdWait;
      end
      StRdWait: begin
        cmd_o.cap_read = 1'b1;
        state_d = StOut;
      end
      // Sweep: one read per cycle, each captured in the state after it
      StSwC: begin
        // capture here is dropped: the center tap restarts the sum next cycle
        cmd_o.rd_sel = SelCur; cmd_o.rd_tap = 3'd0;
        cmd_o.sw_cap = 1'b1; state_d = StSwN;
      end
      StSwN: begin
        cmd_o.sw_cap = 1'b1;
        cmd_o.rd_sel = SelCur; cmd_o.rd_tap = 3'd1; state_d = StSwS;
      end
      StSwS: begin
        cmd_o.sw_cap = 1'b1;
        cmd_o.rd_sel = SelCur; cmd_o.rd_tap = 3'd2; state_d = StSwW;
      end
      StSwW: begin
        cmd_o.sw_cap = 1'b1;
        cmd_o.rd_sel = SelCur; cmd_o.rd_tap = 3'd3; state_d = StSwE;
      end
      StSwE: begin
        cmd_o.sw_cap = 1'b1;
        cmd_o.rd_sel = SelCur; cmd_o.rd_tap = 3'd4; state_d = StSwP;
      end
      StSwP: begin
        cmd_o.sw_cap = 1'b1;
        cmd_o.rd_sel = SelPrev; cmd_o.rd_tap = 3'd0; state_d = StSwWait;
      end
      StSwWait: begin
        cmd_o.sw_capp = 1'b1;
        state_d = StSwMul;
      end
      StSwMul: begin
        cmd_o.sw_mul = 1'b1;
        state_d = StSwSum;
      end
      StSwSum: begin
        cmd_o.sw_sum = 1'b1;
        last_d = sts_i.cell_last;
        state_d = StSwWr;
      end
      StSwWr: begin
        cmd_o.sw_wr = 1'b1;
        if (last_q) begin
          cmd_o.swap = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.cell_inc = 1'b1;
          state_d = StSwC;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign stepped_o  = stepped_q;
  assign rejected_o = rej_q;
  assign is_read_o  = rd_q;

  logic unused;
  assign unused = ^{op_q, row_q, col_q};

endmodule
`default_nettype wire

// File: rtl/wave_grid_stencil_step.sv
// A stepping tick sweeps the interior cells one at a time through one
// shared read port and multiplier stage.
// One item in flight at a time; the result is held until taken.
// After reset both banks are cleared, one address a cycle, over all 2^(log2 rows
// + log2 cols) addresses (4096 by default) before the first item is accepted.
`default_nettype none
module wave_grid_stencil_step #(
  parameter int unsigned GRID_ROWS = 64,
  parameter int unsigned GRID_COLS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[1:0], row[9:2], col[17:10], magnitude[33:18], elapsed[49:34]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // height[15:0], stepped[16], rejected[17]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);
  import wgs_pkg::*;

  logic signed [17:0] k1_q, k2_q, k3_q;
  logic [23:0] period_q;
  logic [7:0] row_q, col_q;
  logic signed [15:0] mag_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic stepped, rejected, is_read;
  logic signed [15:0] rd_val;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      period_q <= 24'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoeffPrev: k1_q <= cfg_data_i[17:0];
        RegCoeffCur:  k2_q <= cfg_data_i[17:0];
        RegCoeffNbr:  k3_q <= cfg_data_i[17:0];
        RegPeriod:    period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold cell and magnitude of the accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      mag_q <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      row_q <= s_axis_tdata[9:2];
      col_q <= s_axis_tdata[17:10];
      mag_q <= s_axis_tdata[33:18];
    end
  end

  wgs_ctrl #(.GridRows(GRID_ROWS), .GridCols(GRID_COLS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tdata[1:0]), .row_i(s_axis_tdata[9:2]),
    .col_i(s_axis_tdata[17:10]), .elapsed_i(s_axis_tdata[49:34]),
    .period_i(period_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stepped_o(stepped), .rejected_o(rejected), .is_read_o(is_read),
    .cmd_o(cmd), .sts_i(sts)
  );

  wgs_datapath #(.GridRows(GRID_ROWS), .GridCols(GRID_COLS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .row_i(row_q), .col_i(col_q),
    .mag_i(mag_q),
    .k1_i(k1_q), .k2_i(k2_q), .k3_i(k3_q), .read_o(rd_val)
  );

  assign m_axis_tdata = {6'd0, rejected, stepped, is_read ? rd_val : 16'sd0};

  logic unused;
  assign unused = ^s_axis_tdata[55:50];

endmodule
`default_nettype wire

// File: verif/wave_grid_stencil_step_test.sv
`timescale 1ns / 100ps
module wave_grid_stencil_step_test;
  import wgs_pkg::*;

  localparam int Rows = 64;
  localparam int Cols = 64;
  localparam int Cells = Rows * Cols;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int StepsPerPhase = 3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  wave_grid_stencil_step #(.GRID_ROWS(Rows), .GRID_COLS(Cols)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic        rejected;
    logic        stepped;
    logic [15:0] height;
  } ripple_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] mag;
    logic [15:0] elapsed;
    bit          typed;
    ripple_res_t res;
  } grid_cmd_t;

  // Shadow grid: two banks, current selects which one is live
  shortint     grid_mem[2][Cells];
  bit          cur_bank;
  logic [24:0] time_acc;
  longint      k_prev, k_cur, k_nbr;
  logic [23:0] period;

  ripple_res_t height_q[$];
  int          fail_cnt = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          steps_left;

  function automatic shortint clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return shortint'(v);
  endfunction

  function automatic bit tick_steps(logic [15:0] el);
    logic [24:0] t;
    t = time_acc + el;
    return t >= {1'b0, period};
  endfunction

  // One sweep of the damped wave update; result goes over the previous bank
  task automatic sweep_grid();
    int     idx;
    longint nsum, acc;
    for (int r = 1; r < Rows - 1; r++) begin
      for (int c = 1; c < Cols - 1; c++) begin
        idx = r * Cols + c;
        nsum = longint'(grid_mem[cur_bank][idx + Cols]) + grid_mem[cur_bank][idx - Cols]
             + grid_mem[cur_bank][idx + 1] + grid_mem[cur_bank][idx - 1];
        acc = k_prev * grid_mem[!cur_bank][idx] + k_cur * grid_mem[cur_bank][idx]
            + k_nbr * nsum;
        grid_mem[!cur_bank][idx] = clamp16((acc + 32768) >>> 16);
      end
    end
    cur_bank = !cur_bank;
  endtask

  task automatic predict_height(input grid_cmd_t cmd, output ripple_res_t res);
    int     idx;
    longint m, half;
    res = '0;
    case (cmd.op)
      OpTick: begin
        time_acc = time_acc + cmd.elapsed;
        if (time_acc >= {1'b0, period}) begin
          sweep_grid();
          time_acc = '0;
          res.stepped = 1'b1;
        end
      end
      OpPerturb: begin
        if (cmd.row < 2 || cmd.row > Rows - 3 || cmd.col < 2 || cmd.col > Cols - 3) begin
          res.rejected = 1'b1;
        end else begin
          idx = cmd.row * Cols + cmd.col;
          m = longint'(signed'(cmd.mag));
          half = m >>> 1;
          grid_mem[cur_bank][idx] = clamp16(grid_mem[cur_bank][idx] + m);
          grid_mem[cur_bank][idx + 1] = clamp16(grid_mem[cur_bank][idx + 1] + half);
          grid_mem[cur_bank][idx - 1] = clamp16(grid_mem[cur_bank][idx - 1] + half);
          grid_mem[cur_bank][idx + Cols] = clamp16(grid_mem[cur_bank][idx + Cols] + half);
          grid_mem[cur_bank][idx - Cols] = clamp16(grid_mem[cur_bank][idx - Cols] + half);
        end
      end
      OpRead: begin
        if (cmd.row >= Rows || cmd.col >= Cols) res.rejected = 1'b1;
        else res.height = grid_mem[cur_bank][cmd.row * Cols + cmd.col];
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegCoeffPrev: k_prev = longint'(signed'(val[17:0]));
      RegCoeffCur:  k_cur = longint'(signed'(val[17:0]));
      RegCoeffNbr:  k_nbr = longint'(signed'(val[17:0]));
      default:      period = val;
    endcase
  endtask

  task automatic set_coeffs(input int kp, input int kc, input int kn, input int per);
    write_reg(RegCoeffPrev, 24'(kp));
    write_reg(RegCoeffCur, 24'(kc));
    write_reg(RegCoeffNbr, 24'(kn));
    write_reg(RegPeriod, 24'(per));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Predict, queue the expectation, then drive until the transaction is taken
  task automatic send_cmd(input grid_cmd_t cmd);
    ripple_res_t res;
    predict_height(cmd, res);
    height_q.push_back(cmd.typed ? cmd.res : res);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < send_idle) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, cmd.elapsed, cmd.mag, cmd.col, cmd.row, cmd.op};
        break;
      end
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (height_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic grid_cmd_t row_of(logic [1:0] op, int r, int c, int mg, int el);
    grid_cmd_t cmd;
    cmd.op = op;
    cmd.row = 8'(r);
    cmd.col = 8'(c);
    cmd.mag = 16'(mg);
    cmd.elapsed = 16'(el);
    cmd.typed = 1'b0;
    cmd.res = '0;
    return cmd;
  endfunction

  function automatic grid_cmd_t typed_row(logic [1:0] op, int r, int c, int mg, int el,
                                          ripple_res_t res);
    grid_cmd_t cmd;
    cmd = row_of(op, r, c, mg, el);
    cmd.typed = 1'b1;
    cmd.res = res;
    return cmd;
  endfunction

  function automatic grid_cmd_t random_cmd();
    grid_cmd_t cmd;
    int        pick;
    cmd = row_of(OpUnused, $urandom_range(255), $urandom_range(255), $urandom, 0);
    cmd.elapsed = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      cmd.op = OpPerturb;
      if ($urandom_range(9) < 8) begin
        cmd.row = 8'($urandom_range(Rows - 3, 2));
        cmd.col = 8'($urandom_range(Cols - 3, 2));
      end
    end else if (pick < 70) begin
      cmd.op = OpRead;
      if ($urandom_range(9) < 8) begin
        cmd.row = 8'($urandom_range(Rows - 1));
        cmd.col = 8'($urandom_range(Cols - 1));
      end
    end else if (pick < 95) begin
      cmd.op = OpTick;
      if ($urandom_range(9) < 8) cmd.elapsed = 16'($urandom_range(1200));
    end
    // Keep full sweeps rare so the run stays short
    if (cmd.op == OpTick && tick_steps(cmd.elapsed)) begin
      if (steps_left > 0) steps_left--;
      else cmd.op = OpRead;
    end
    return cmd;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    ripple_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[17:0];
      if (height_q.size() == 0) begin
        $error("unexpected result %h", got);
        fail_cnt++;
      end else begin
        want = height_q.pop_front();
        if (got.height !== want.height) begin
          $error("height: expected %h actual %h", want.height, got.height);
          fail_cnt++;
        end
        if (got.stepped !== want.stepped) begin
          $error("stepped: expected %b actual %b", want.stepped, got.stepped);
          fail_cnt++;
        end
        if (got.rejected !== want.rejected) begin
          $error("rejected: expected %b actual %b", want.rejected, got.rejected);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    grid_cmd_t   dir_tbl[$];
    ripple_res_t zero_r, rej_r, step_r;
    int          idle_tbl[4][2];

    zero_r = '0;
    rej_r = '0;
    rej_r.rejected = 1'b1;
    step_r = '0;
    step_r.stepped = 1'b1;
    idle_tbl = '{'{0, 0}, '{87, 0}, '{0, 87}, '{24, 24}};

    for (int b = 0; b < 2; b++) foreach (grid_mem[b][i]) grid_mem[b][i] = 0;
    cur_bank = 1'b0;
    time_acc = '0;
    k_prev = 0;
    k_cur = 0;
    k_nbr = 0;
    period = 24'd1000;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: range limits, saturation, stepping at the period, unused opcode
    dir_tbl.push_back(typed_row(OpRead, 0, 0, 0, 0, zero_r));
    dir_tbl.push_back(typed_row(OpRead, 63, 63, 0, 0, zero_r));
    dir_tbl.push_back(typed_row(OpRead, 64, 0, 0, 0, rej_r));
    dir_tbl.push_back(typed_row(OpRead, 0, 64, 0, 0, rej_r));
    dir_tbl.push_back(typed_row(OpRead, 255, 255, 0, 65535, rej_r));
    dir_tbl.push_back(typed_row(OpPerturb, 1, 10, 1000, 0, rej_r));
    dir_tbl.push_back(typed_row(OpPerturb, 10, 1, 1000, 0, rej_r));
    dir_tbl.push_back(typed_row(OpPerturb, 62, 5, 1000, 0, rej_r));
    dir_tbl.push_back(typed_row(OpPerturb, 5, 62, 1000, 0, rej_r));
    dir_tbl.push_back(typed_row(OpPerturb, 255, 255, -1, 0, rej_r));
    dir_tbl.push_back(row_of(OpPerturb, 2, 2, 32767, 0));
    dir_tbl.push_back(row_of(OpPerturb, 61, 61, -32768, 0));
    dir_tbl.push_back(row_of(OpPerturb, 10, 10, 32767, 0));
    dir_tbl.push_back(row_of(OpPerturb, 10, 10, 32767, 0));
    dir_tbl.push_back(row_of(OpPerturb, 20, 20, -3, 0));
    dir_tbl.push_back(row_of(OpRead, 10, 10, 0, 0));
    dir_tbl.push_back(row_of(OpRead, 10, 11, 0, 0));
    dir_tbl.push_back(row_of(OpRead, 19, 20, 0, 0));
    dir_tbl.push_back(typed_row(OpRead, 1, 0, 0, 0, zero_r));
    dir_tbl.push_back(typed_row(OpUnused, 10, 10, -1, 65535, zero_r));
    dir_tbl.push_back(typed_row(OpTick, 0, 0, 0, 999, zero_r));
    dir_tbl.push_back(typed_row(OpTick, 0, 0, 0, 1, step_r));
    dir_tbl.push_back(typed_row(OpRead, 10, 10, 0, 0, zero_r));
    dir_tbl.push_back(typed_row(OpTick, 255, 255, -1, 65535, step_r));
    foreach (dir_tbl[i]) send_cmd(dir_tbl[i]);
    drain();

    // Random phases, each with its own coefficients, period and idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_coeffs(-65536, 65536, 32768, 3000);
        1: set_coeffs(131071, -131072, 131071, 16777215);
        2: set_coeffs(-131072, 131071, -131072, 0);
        default: set_coeffs(0, -65536, 16384, 500);
      endcase
      send_idle = idle_tbl[ph][0];
      recv_stall = idle_tbl[ph][1];
      steps_left = StepsPerPhase;
      repeat (25) send_cmd(random_cmd());
      send_idle = 0;
      recv_stall = 0;
      repeat (4) send_cmd(random_cmd());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wgs_pkg.sv
rtl/wgs_datapath.sv
rtl/wgs_ctrl.sv
rtl/wave_grid_stencil_step.sv
verif/wave_grid_stencil_step_test.sv
